// ===== sv/one_wire_temperature_reader_defines.svh =====
// ----------------------------------------------------------------------------
// One-wire temperature reader assertion macros
// Implication checks, same-cycle and next-cycle, sampled on the rising edge.
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_TEMPERATURE_READER_DEFINES_SVH
`define ONE_WIRE_TEMPERATURE_READER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define OWTR_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: ante implies cons");
`define OWTR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: ante implies cons on the next edge");
`else
`define OWTR_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define OWTR_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== sv/owtr_pkg.sv =====
// ----------------------------------------------------------------------------
// One-wire temperature reader package
// Command bytes, register indexes, port widths and the result layout.
// ----------------------------------------------------------------------------
package owtr_pkg;

    localparam int CFG_DATA_W = 20;
    localparam int CFG_ADDR_W = 3;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 24;

    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_CONVERT    = 8'h44;
    localparam logic [7:0] CMD_READ_SCRPD = 8'hBE;

    localparam logic [7:0] CMD_BYTES [0:3] = '{
        CMD_SKIP_ROM, CMD_CONVERT, CMD_SKIP_ROM, CMD_READ_SCRPD
    };

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_RESET_LOW     = 3'd0,
        REG_PRESENCE_WAIT = 3'd1,
        REG_PRESENCE_REC  = 3'd2,
        REG_SLOT          = 3'd3,
        REG_LOW_PULSE     = 3'd4,
        REG_SAMPLE_DELAY  = 3'd5,
        REG_CONVERT_WAIT  = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [3:0]  pad;
        logic        no_presence;
        logic [15:0] temperature_word;
        logic        done_res;
        logic        busy_res;
        logic        drive_low;
    } result_t;

endpackage

// ===== sv/one_wire_temperature_reader.sv =====
// ----------------------------------------------------------------------------
// One-wire temperature reader
// Bus master sequencer running reset, skip-ROM, convert, wait, reset,
// skip-ROM, read-scratchpad and a two-byte read, one item per bus tick.
// Result: each accepted item yields one registered result item.
// Throughput: 1 item per cycle while the output is not stalled by m_tready;
// the sequencer state register closes the loop. Reset: aresetn synchronous,
// active low; idle state, defaults in timing regs.
`include "one_wire_temperature_reader_defines.svh"

module one_wire_temperature_reader #(
    parameter int COUNTER_WIDTH   = 20,
    parameter int PRE_RESET_TICKS = 15
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [owtr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [owtr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [owtr_pkg::S_TDATA_W-1:0]      s_tdata,  // start_req, bus_level
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // drive_low, busy_res, done_res, temperature_word[15:0], no_presence
    output logic [owtr_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int CW    = COUNTER_WIDTH;
    localparam int CMP_W = ((CW > 20) ? CW : 20) + 1;

    typedef enum logic [3:0] {
        PH_IDLE, PH_PRE, PH_RLOW, PH_RWAIT, PH_RREC,
        PH_WBIT, PH_WREC, PH_CONV, PH_RBIT, PH_DONE
    } phase_t;

    logic [11:0] rlow_reg, pwait_reg, prec_reg, slot_reg;
    logic [3:0]  lowp_reg, samp_reg;
    logic [19:0] conv_reg;

    phase_t      phase_reg, phase_next;
    logic [2:0]  cmd_idx_reg, cmd_idx_next;
    logic [2:0]  bit_idx_reg, bit_idx_next;
    logic [7:0]  shift_reg, shift_next;
    logic [CW-1:0] tick_reg, tick_next;
    logic [15:0] temp_reg, temp_next;
    logic        pmiss_reg, pmiss_next;

    owtr_pkg::result_t res_reg, res_next;
    logic        m_tvalid_reg;

    logic             accept;
    logic             start_req, bus_level;
    logic [CMP_W-1:0] tick_ext, tn;
    logic             end_tick;
    logic [4:0]       sp_sum;
    logic [11:0]      sp;
    logic             idle_no_start;

    assign start_req = s_tdata[0];
    assign bus_level = s_tdata[1];
    assign s_tready  = aresetn && (!m_tvalid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = res_reg;

    assign idle_no_start = accept && (phase_reg == PH_IDLE) && !start_req;

    assign tick_ext = CMP_W'(tick_reg);
    assign sp_sum   = {1'b0, lowp_reg} + {1'b0, samp_reg};
    assign sp       = ({7'd0, sp_sum} > slot_reg) ? slot_reg : {7'd0, sp_sum};

    always_comb begin
        unique case (phase_reg)
            PH_PRE:   tn = CMP_W'(PRE_RESET_TICKS);
            PH_RLOW:  tn = CMP_W'(rlow_reg);
            PH_RWAIT: tn = CMP_W'(pwait_reg);
            PH_RREC:  tn = CMP_W'(prec_reg);
            PH_WBIT:  tn = CMP_W'(slot_reg) + CMP_W'(1);
            PH_RBIT:  tn = CMP_W'(slot_reg) + CMP_W'(1);
            PH_WREC:  tn = CMP_W'(slot_reg);
            PH_CONV:  tn = CMP_W'(conv_reg);
            default:  tn = CMP_W'(1);
        endcase
        end_tick = (tick_ext + CMP_W'(1) >= tn) || (tick_reg == {CW{1'b1}});
    end

    always_comb begin
        phase_next   = phase_reg;
        cmd_idx_next = cmd_idx_reg;
        bit_idx_next = bit_idx_reg;
        shift_next   = shift_reg;
        tick_next    = end_tick ? '0 : tick_reg + CW'(1);
        temp_next    = temp_reg;
        pmiss_next   = pmiss_reg;

        res_next                  = '0;
        res_next.busy_res         = (phase_reg != PH_IDLE) && (phase_reg != PH_DONE);
        res_next.drive_low        = 1'b0;
        res_next.done_res         = (phase_reg == PH_DONE);
        res_next.temperature_word = (phase_reg == PH_DONE) ? temp_reg : 16'd0;

        unique case (phase_reg)
            PH_IDLE: begin
                tick_next = tick_reg;
                if (start_req) begin
                    pmiss_next   = 1'b0;
                    cmd_idx_next = '0;
                    phase_next   = PH_PRE;
                    tick_next    = '0;
                end
            end
            PH_PRE: begin
                if (end_tick) phase_next = PH_RLOW;
            end
            PH_RLOW: begin
                res_next.drive_low = 1'b1;
                if (end_tick) phase_next = PH_RWAIT;
            end
            PH_RWAIT: begin
                if (end_tick) phase_next = PH_RREC;
            end
            PH_RREC: begin
                if (tick_reg == '0 && bus_level) pmiss_next = 1'b1;
                if (end_tick) begin
                    shift_next   = owtr_pkg::CMD_BYTES[cmd_idx_reg[1:0]];
                    bit_idx_next = '0;
                    phase_next   = PH_WBIT;
                end
            end
            PH_WBIT: begin
                res_next.drive_low = (tick_ext < CMP_W'(slot_reg))
                    && ((tick_ext < CMP_W'(lowp_reg)) || !shift_reg[0]);
                if (end_tick) begin
                    shift_next = {1'b0, shift_reg[7:1]};
                    if (bit_idx_reg == 3'd7) begin
                        phase_next = PH_WREC;
                    end else begin
                        bit_idx_next = bit_idx_reg + 3'd1;
                    end
                end
            end
            PH_WREC: begin
                if (end_tick) begin
                    if (cmd_idx_reg == 3'd1) begin
                        cmd_idx_next = 3'd2;
                        phase_next   = PH_CONV;
                    end else if (cmd_idx_reg >= 3'd3) begin
                        cmd_idx_next = 3'd4;
                        bit_idx_next = '0;
                        shift_next   = '0;
                        phase_next   = PH_RBIT;
                    end else begin
                        cmd_idx_next = cmd_idx_reg + 3'd1;
                        shift_next   = owtr_pkg::CMD_BYTES[cmd_idx_next[1:0]];
                        bit_idx_next = '0;
                        phase_next   = PH_WBIT;
                    end
                end
            end
            PH_CONV: begin
                if (end_tick) phase_next = PH_PRE;
            end
            PH_RBIT: begin
                res_next.drive_low = (tick_ext < CMP_W'(slot_reg))
                    && (tick_ext < CMP_W'(lowp_reg));
                if (tick_ext == CMP_W'(sp)) shift_next = {bus_level, shift_reg[7:1]};
                if (end_tick) begin
                    if (bit_idx_reg != 3'd7) begin
                        bit_idx_next = bit_idx_reg + 3'd1;
                    end else if (cmd_idx_reg == 3'd4) begin
                        temp_next    = {temp_reg[15:8], shift_next};
                        cmd_idx_next = 3'd5;
                        bit_idx_next = '0;
                        shift_next   = '0;
                    end else begin
                        temp_next  = {shift_next, temp_reg[7:0]};
                        phase_next = PH_DONE;
                    end
                end
            end
            default: begin
                cmd_idx_next = '0;
                bit_idx_next = '0;
                tick_next    = '0;
                phase_next   = PH_IDLE;
            end
        endcase

        res_next.no_presence = pmiss_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rlow_reg     <= 12'd800;
            pwait_reg    <= 12'd100;
            prec_reg     <= 12'd50;
            slot_reg     <= 12'd55;
            lowp_reg     <= 4'd1;
            samp_reg     <= 4'd1;
            conv_reg     <= 20'd10000;
            phase_reg    <= PH_IDLE;
            cmd_idx_reg  <= '0;
            bit_idx_reg  <= '0;
            shift_reg    <= '0;
            tick_reg     <= '0;
            temp_reg     <= '0;
            pmiss_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    owtr_pkg::REG_RESET_LOW:     rlow_reg  <= cfg_wdata[11:0];
                    owtr_pkg::REG_PRESENCE_WAIT: pwait_reg <= cfg_wdata[11:0];
                    owtr_pkg::REG_PRESENCE_REC:  prec_reg  <= cfg_wdata[11:0];
                    owtr_pkg::REG_SLOT:          slot_reg  <= cfg_wdata[11:0];
                    owtr_pkg::REG_LOW_PULSE:     lowp_reg  <= cfg_wdata[3:0];
                    owtr_pkg::REG_SAMPLE_DELAY:  samp_reg  <= cfg_wdata[3:0];
                    owtr_pkg::REG_CONVERT_WAIT:  conv_reg  <= cfg_wdata[19:0];
                    default: ;
                endcase
            end
            if (accept) begin
                phase_reg   <= phase_next;
                cmd_idx_reg <= cmd_idx_next;
                bit_idx_reg <= bit_idx_next;
                shift_reg   <= shift_next;
                tick_reg    <= tick_next;
                temp_reg    <= temp_next;
                pmiss_reg   <= pmiss_next;
            end
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    `OWTR_ASSERT_IMPLIES(a_done_not_busy, aclk, aresetn, m_tvalid && m_tdata[2], !m_tdata[1])
    `OWTR_ASSERT_IMPLIES(a_drive_only_busy, aclk, aresetn, m_tvalid && m_tdata[0], m_tdata[1])
    `OWTR_ASSERT_IMPLIES(a_cmd_range, aclk, aresetn, 1'b1, cmd_idx_reg <= 3'd5)
    `OWTR_ASSERT_NEXT(a_idle_no_start, aclk, aresetn, idle_no_start, phase_reg == PH_IDLE)

endmodule
